>>> sv/bh_curve_interpolator_macros.svh
// Assertion helpers for the checked module.
`ifndef BH_CURVE_INTERPOLATOR_MACROS_SVH
`define BH_CURVE_INTERPOLATOR_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define BHCI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BHCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bhci_pkg.sv
package bhci_pkg;

    localparam int COUNT_W = 5;
    localparam int H_W     = 32;
    localparam int R_W     = 40;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FIELD  = 2'd1;
    localparam logic [1:0] OP_RELUCT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [H_W-1:0] H_MAX = 32'hFFFF_FFFF;
    localparam logic [R_W-1:0] R_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  sample_index;
        logic [23:0] flux_b;
        logic [31:0] field_h;
    } t_in_beat;

    typedef struct packed {
        logic [39:0] result_value;
        logic [1:0]  status;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_CHK,
        S_SETUP,
        S_DIV,
        S_ADDH,
        S_RFIN,
        S_OUT
    } t_state;

endpackage

>>> sv/bhci_ram.sv
module bhci_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bh_curve_interpolator.sv
// Channel  | valid       | stall        | beat
// ---------+-------------+--------------+-----------------------------
// input    | i_in_valid  | o_in_stall   | i_in_beat  (t_in_beat)
// output   | o_out_valid | i_out_stall  | o_out_beat (t_out_beat)
// config   | i_cfg_we    | -            | i_cfg_data (sample_count)
//
// Loads and unused opcodes are taken in idle. A query walks the table, a request
// and a check state per sample (n = sample_count), then runs a one-bit-per-cycle
// divider of NW = B_WIDTH+32 steps: once for a field query or a zero-flux
// reluctivity, twice for other reluctivity; a bad sample_count goes straight to S_OUT.
// The single read port of the sample RAM sets the request and check per sample.
// Reset (sync, active low) clears control and sets sample_count to 2; the table
// is not cleared. A stalled result holds in the output register while the next
// query already runs; only its final write waits.
`include "bh_curve_interpolator_macros.svh"

module bh_curve_interpolator #(
    parameter int MAX_SAMPLES = 16,
    parameter int B_WIDTH     = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bhci_pkg::t_in_beat           i_in_beat,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bhci_pkg::t_out_beat          o_out_beat,
    input  logic                         i_cfg_we,
    input  logic [bhci_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int IW     = $clog2(MAX_SAMPLES);
    localparam int XW     = IW + 6;
    localparam int B_FRAC = B_WIDTH - 4;
    localparam int NW     = B_WIDTH + 32;
    localparam int CNTW   = $clog2(NW);
    localparam int EW     = B_WIDTH + 32;

    bhci_pkg::t_state r_state, n_state;

    logic [bhci_pkg::COUNT_W-1:0] r_count;
    logic [1:0]         r_op;
    logic [B_WIDTH-1:0] r_q;
    logic [IW-1:0]      r_idx;
    logic               r_found;
    logic               r_phase;
    logic               r_sat;
    logic [B_WIDTH-1:0] r_prev_b, r_lo_b, r_hi_b;
    logic [31:0]        r_prev_h, r_lo_h, r_hi_h;
    logic [NW-1:0]      r_num;
    logic [B_WIDTH-1:0] r_den;
    logic [B_WIDTH-1:0] r_rem;
    logic [CNTW-1:0]    r_cnt;
    logic [31:0]        r_base_h;
    logic [39:0]        r_res;
    logic [1:0]         r_status;
    logic               r_ovalid;
    bhci_pkg::t_out_beat r_obeat;

    logic               in_acc, is_query, count_bad, out_free;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;
    logic [B_WIDTH-1:0] rd_b;
    logic [31:0]        rd_h;
    logic               last, fail, take_seg, zero_ratio, extrap;
    logic [B_WIDTH-1:0] base_b;
    logic [NW-1:0]      product;
    logic [B_WIDTH:0]   div_t, div_sub;
    logic               div_ge;
    logic [32:0]        h_sum;
    logic               h_sat;
    logic [31:0]        h_val;
    logic               ratio_ovf;

    bhci_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_SAMPLES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    // datapath decode
    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        is_query  = i_in_beat.opcode == bhci_pkg::OP_FIELD ||
                    i_in_beat.opcode == bhci_pkg::OP_RELUCT;
        count_bad = r_count < bhci_pkg::COUNT_W'(2) ||
                    XW'(r_count) > XW'(MAX_SAMPLES);
        out_free  = !r_ovalid || !i_out_stall;
        rd_b      = ram_rdata[B_WIDTH-1:0];
        rd_h      = ram_rdata[B_WIDTH +: 32];
        last      = XW'(r_idx) + XW'(1) == XW'(r_count);
        if (r_idx == '0) begin
            fail = rd_b != '0 || rd_h != '0;
        end else begin
            fail = !(rd_b > r_prev_b) || !(rd_h > r_prev_h);
        end
        // first sample above the query, else the last one
        take_seg   = r_idx != '0 && !r_found && (rd_b > r_q || last);
        zero_ratio = r_op == bhci_pkg::OP_RELUCT && r_q == '0;
        extrap     = r_q >= r_hi_b;
        base_b     = extrap ? r_hi_b : r_lo_b;
        product    = NW'(r_q - base_b) * NW'(r_hi_h - r_lo_h);
        div_t      = {r_rem, r_num[NW-1]};
        div_sub    = div_t - {1'b0, r_den};
        div_ge     = div_t >= {1'b0, r_den};
        h_sum      = {1'b0, r_base_h} + {1'b0, r_num[31:0]};
        h_sat      = r_num[NW-1:32] != '0 || h_sum[32];
        h_val      = h_sat ? bhci_pkg::H_MAX : h_sum[31:0];
        ratio_ovf  = r_num[NW-1:40] != '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bhci_pkg::S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = count_bad ? bhci_pkg::S_OUT : bhci_pkg::S_REQ;
                end
            end
            bhci_pkg::S_REQ: n_state = bhci_pkg::S_CHK;
            bhci_pkg::S_CHK: begin
                if (fail) begin
                    n_state = bhci_pkg::S_OUT;
                end else if (last) begin
                    n_state = bhci_pkg::S_SETUP;
                end else begin
                    n_state = bhci_pkg::S_REQ;
                end
            end
            bhci_pkg::S_SETUP: n_state = bhci_pkg::S_DIV;
            bhci_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_phase ? bhci_pkg::S_RFIN : bhci_pkg::S_ADDH;
                end
            end
            bhci_pkg::S_ADDH: begin
                n_state = (r_op == bhci_pkg::OP_FIELD) ? bhci_pkg::S_OUT : bhci_pkg::S_DIV;
            end
            bhci_pkg::S_RFIN: n_state = bhci_pkg::S_OUT;
            bhci_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = bhci_pkg::S_IDLE;
                end
            end
            default: n_state = bhci_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        case (r_state)
            bhci_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                ram_we     = i_in_valid && i_in_beat.opcode == bhci_pkg::OP_LOAD &&
                             32'(i_in_beat.sample_index) < MAX_SAMPLES;
            end
            default: o_in_stall = 1'b1;
        endcase
        ram_waddr = IW'(i_in_beat.sample_index);
        ram_wdata = {i_in_beat.field_h, B_WIDTH'(i_in_beat.flux_b)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bhci_pkg::S_IDLE;
            r_count  <= bhci_pkg::COUNT_W'(2);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_state == bhci_pkg::S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bhci_pkg::S_IDLE: begin
                r_op     <= i_in_beat.opcode;
                r_q      <= B_WIDTH'(i_in_beat.flux_b);
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_phase  <= 1'b0;
                r_sat    <= 1'b0;
                r_res    <= '0;
                r_status <= bhci_pkg::ST_INVALID;
            end
            bhci_pkg::S_CHK: begin
                r_prev_b <= rd_b;
                r_prev_h <= rd_h;
                r_idx    <= r_idx + IW'(1);
                if (take_seg) begin
                    r_lo_b  <= r_prev_b;
                    r_lo_h  <= r_prev_h;
                    r_hi_b  <= rd_b;
                    r_hi_h  <= rd_h;
                    r_found <= 1'b1;
                end
            end
            bhci_pkg::S_SETUP: begin
                r_rem <= '0;
                r_cnt <= CNTW'(NW - 1);
                if (zero_ratio) begin
                    r_num   <= NW'({r_hi_h, {B_FRAC{1'b0}}});
                    r_den   <= r_hi_b;
                    r_phase <= 1'b1;
                end else begin
                    r_num    <= product;
                    r_den    <= r_hi_b - r_lo_b;
                    r_base_h <= extrap ? r_hi_h : r_lo_h;
                end
            end
            bhci_pkg::S_DIV: begin
                r_rem <= div_ge ? div_sub[B_WIDTH-1:0] : div_t[B_WIDTH-1:0];
                r_num <= {r_num[NW-2:0], div_ge};
                r_cnt <= r_cnt - CNTW'(1);
            end
            bhci_pkg::S_ADDH: begin
                r_sat    <= h_sat;
                r_res    <= {8'd0, h_val};
                r_status <= h_sat ? bhci_pkg::ST_SAT : bhci_pkg::ST_OK;
                // reluctivity: divide H by the query flux
                r_num    <= NW'({h_val, {B_FRAC{1'b0}}});
                r_den    <= r_q;
                r_rem    <= '0;
                r_cnt    <= CNTW'(NW - 1);
                r_phase  <= 1'b1;
            end
            bhci_pkg::S_RFIN: begin
                r_res    <= ratio_ovf ? bhci_pkg::R_MAX : r_num[39:0];
                r_status <= (ratio_ovf || r_sat) ? bhci_pkg::ST_SAT : bhci_pkg::ST_OK;
            end
            bhci_pkg::S_OUT: begin
                if (out_free) begin
                    r_obeat.result_value <= r_res;
                    r_obeat.status       <= r_status;
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

    `BHCI_ASSERT_ALWAYS(a_load_only_idle, !ram_we || r_state == bhci_pkg::S_IDLE, "table write outside idle")
    `BHCI_ASSERT_NEXT(a_query_start, in_acc && is_query, r_state == bhci_pkg::S_REQ || r_state == bhci_pkg::S_OUT, "query did not start")
    `BHCI_ASSERT_NEXT(a_div_end, r_state == bhci_pkg::S_DIV && r_cnt == '0, r_state == bhci_pkg::S_ADDH || r_state == bhci_pkg::S_RFIN, "divider overran")
    `BHCI_ASSERT_NEXT(a_result_out, r_state == bhci_pkg::S_OUT && out_free, o_out_valid && r_state == bhci_pkg::S_IDLE, "result not posted")

endmodule

>>> tb/sv/bhci_checker.sv
module bhci_checker
    import bhci_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_beat           i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_beat          i_out_beat,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    output int                 o_failures,
    output int                 o_pending
);

    logic [23:0]        curve_b [16];
    logic [31:0]        curve_h [16];
    logic [COUNT_W-1:0] n_samples;
    t_out_beat          expected_results [$];
    int                 fail_count;

    initial begin
        fail_count = 0;
        o_failures = 0;
        o_pending  = 0;
    end

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("checker: %s expected %0h got %0h at %0t", what, want, got, $time);
        fail_count++;
    endtask

    function automatic bit curve_valid();
        if (n_samples < 2 || n_samples > 16) return 1'b0;
        if (curve_b[0] != 0 || curve_h[0] != 0) return 1'b0;
        for (int i = 1; i < n_samples; i++)
            if (curve_b[i] <= curve_b[i-1] || curve_h[i] <= curve_h[i-1]) return 1'b0;
        return 1'b1;
    endfunction

    // H at flux b; table assumed valid
    function automatic logic [63:0] field_at(input logic [63:0] b, inout bit sat);
        int          last;
        int          hi;
        logic [63:0] extra;
        logic [63:0] h;
        last = n_samples - 1;
        if (b >= curve_b[last]) begin
            extra = ((b - curve_b[last]) * (curve_h[last] - curve_h[last-1]))
                    / (curve_b[last] - curve_b[last-1]);
            h = curve_h[last] + extra;
            if (extra > H_MAX || h > H_MAX) begin
                sat = 1'b1;
                h   = H_MAX;
            end
            return h;
        end
        hi = 1;
        while (hi < last && !(curve_b[hi] > b)) hi++;
        return curve_h[hi-1] + ((b - curve_b[hi-1]) * (curve_h[hi] - curve_h[hi-1]))
                               / (curve_b[hi] - curve_b[hi-1]);
    endfunction

    function automatic logic [63:0] reluct_of(input logic [63:0] h, input logic [63:0] b,
                                              inout bit sat);
        logic [63:0] r;
        r = (h << 20) / b;
        if (r > R_MAX) begin
            sat = 1'b1;
            r   = R_MAX;
        end
        return r;
    endfunction

    // applies one input beat; returns 1 when it yields a result
    function automatic bit curve_response(input t_in_beat beat, output t_out_beat res);
        bit          sat;
        logic [63:0] v;
        logic [63:0] hv;
        sat = 1'b0;
        res = '0;
        if (beat.opcode == OP_LOAD) begin
            curve_b[beat.sample_index] = beat.flux_b;
            curve_h[beat.sample_index] = beat.field_h;
            return 1'b0;
        end
        if (beat.opcode == OP_NONE) return 1'b0;
        if (!curve_valid()) begin
            res.status = ST_INVALID;
            return 1'b1;
        end
        if (beat.opcode == OP_FIELD)
            v = field_at(beat.flux_b, sat);
        else if (beat.flux_b == 0)
            v = reluct_of(curve_h[1], curve_b[1], sat);
        else begin
            // H first, so a saturated H carries into the ratio flag
            hv = field_at(beat.flux_b, sat);
            v  = reluct_of(hv, beat.flux_b, sat);
        end
        res.result_value = v[39:0];
        res.status       = sat ? ST_SAT : ST_OK;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            n_samples = COUNT_W'(2);
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_out_beat.result_value);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_beat.result_value !== want.result_value)
                        report_mismatch("result_value", want.result_value,
                                        i_out_beat.result_value);
                    if (i_out_beat.status !== want.status)
                        report_mismatch("status", 40'(want.status), 40'(i_out_beat.status));
                end
            end
            if (i_in_valid && !i_in_stall)
                if (curve_response(i_in_beat, want)) expected_results = {expected_results, want};
            if (i_cfg_we) n_samples = i_cfg_data;
        end
        o_pending  <= expected_results.size();
        o_failures <= fail_count;
    end

endmodule

>>> tb/sv/tb_bh_curve_interpolator.sv
module tb_bh_curve_interpolator;
    import bhci_pkg::*;

    localparam int ITEMS      = 1250;
    localparam int DRAIN      = 200;
    localparam int CYCLE_CAP  = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_beat           i_in_beat;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_beat          o_out_beat;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;

    int          failures;
    int          pending;
    int          cycles;
    int          sent;
    int          idle_mode;
    logic [23:0] tab_b [16];
    logic [31:0] tab_h [16];
    int          n_cur;

    bh_curve_interpolator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    bhci_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        cycles      = 0;
        sent        = 0;
        idle_mode   = 0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("bh_curve_interpolator: mismatch");
            $finish;
        end
    end

    // receiver side: stalls 51% then 19% then never
    always @(posedge i_clk) begin
        if (!i_rst_n || idle_mode == 2)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < (idle_mode == 0 ? 51 : 19));
    end

    // holds valid high until the beat is taken; returns on the accepting edge
    task automatic send_beat(input logic [1:0] op, input logic [3:0] idx,
                             input logic [23:0] b, input logic [31:0] h);
        i_in_valid          <= 1'b1;
        i_in_beat.opcode       <= op;
        i_in_beat.sample_index <= idx;
        i_in_beat.flux_b       <= b;
        i_in_beat.field_h      <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        idle_mode = (sent < ITEMS / 3) ? 0 : (sent < 2 * ITEMS / 3) ? 1 : 2;
        if (idle_mode != 2 && $urandom_range(99) < (idle_mode == 0 ? 19 : 51)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // kind: 0 gentle, 1 steep throughout, 2 corrupted, 3 random contents
    task automatic load_curve(input int kind);
        int k;
        tab_b[0] = '0;
        tab_h[0] = '0;
        for (int i = 1; i < 16; i++) begin
            if (kind == 1) begin
                tab_b[i] = 24'(tab_b[i-1] + $urandom_range(1, 16));
                tab_h[i] = tab_h[i-1] + $urandom_range(1, 1 << 28);
            end else begin
                tab_b[i] = 24'(tab_b[i-1] + $urandom_range(1, 1 << 20));
                tab_h[i] = tab_h[i-1] + ($urandom_range(1) ? $urandom_range(1, 1 << 28)
                                                           : $urandom_range(1, 4096));
            end
        end
        if (kind == 2) begin
            k = $urandom_range(1, 15);
            case ($urandom_range(3))
                0: tab_b[0] = 24'($urandom_range(1, 1 << 23));
                1: tab_h[0] = $urandom;
                2: tab_b[k] = tab_b[k-1];
                default: tab_h[k] = tab_h[k-1] - $urandom_range(1);
            endcase
        end else if (kind == 3) begin
            for (int i = 0; i < 16; i++) begin
                tab_b[i] = 24'($urandom);
                tab_h[i] = $urandom;
            end
        end
        for (int i = 0; i < 16; i++) send_beat(OP_LOAD, 4'(i), tab_b[i], tab_h[i]);
    endtask

    function automatic logic [23:0] pick_flux();
        int k;
        k = $urandom_range(1, (n_cur >= 2 && n_cur <= 16) ? n_cur - 1 : 15);
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return tab_b[k];
            2: return 24'(tab_b[k] + $urandom_range(0, 8) - 4);
            3: return tab_b[k-1] + (tab_b[k] - tab_b[k-1]) / 2;
            4: return '0;
            default: return 24'(24'hFF_FFFF - $urandom_range(0, 1 << 16));
        endcase
    endfunction

    initial begin
        int kind;
        int phase;
        logic [1:0] op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two-sample curves, extremes, zero flux, overflow, bad origin
        idle_mode = 2;
        n_cur = 2;
        send_beat(OP_LOAD, 0, 24'd0, 32'd0);
        send_beat(OP_LOAD, 1, 24'd1, 32'hFFFF_FFFF);
        send_beat(OP_FIELD, 0, 24'd0, 32'd0);
        send_beat(OP_FIELD, 0, 24'd1, 32'd0);
        send_beat(OP_FIELD, 0, 24'd2, 32'd0);
        send_beat(OP_FIELD, 0, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_RELUCT, 0, 24'd0, 32'd0);
        send_beat(OP_RELUCT, 0, 24'hFF_FFFF, 32'd0);
        send_beat(OP_LOAD, 1, 24'h10_0000, 32'h100);
        send_beat(OP_FIELD, 15, 24'h08_0000, 32'd0);
        send_beat(OP_RELUCT, 0, 24'd0, 32'd0);
        send_beat(OP_RELUCT, 0, 24'h08_0000, 32'd0);
        send_beat(OP_RELUCT, 0, 24'hFF_FFFF, 32'd0);
        send_beat(OP_NONE, 4'hF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_LOAD, 0, 24'd5, 32'd0);
        send_beat(OP_FIELD, 0, 24'd7, 32'd0);
        send_beat(OP_LOAD, 0, 24'd0, 32'd1);
        send_beat(OP_RELUCT, 0, 24'd7, 32'd0);
        send_beat(OP_LOAD, 0, 24'd0, 32'd0);
        send_beat(OP_FIELD, 0, 24'h0F_FFFF, 32'd0);
        sent = 0;

        phase = 0;
        while (sent < ITEMS) begin
            wait_quiet();
            case (phase % 9)
                0, 4:    n_cur = 16;
                1:       n_cur = 2;
                2:       n_cur = 31;
                3, 6, 8: n_cur = $urandom_range(2, 16);
                5:       n_cur = phase % 2;
                default: n_cur = 17;
            endcase
            write_count(COUNT_W'(n_cur));
            kind = $urandom_range(99);
            kind = (kind < 60) ? 0 : (kind < 80) ? 1 : (kind < 92) ? 2 : 3;
            load_curve(kind);
            repeat ($urandom_range(20, 50)) begin
                op = $urandom_range(99) < 45 ? OP_FIELD
                   : $urandom_range(99) < 90 ? OP_RELUCT : OP_NONE;
                if ($urandom_range(99) < 3) begin
                    // stray load to an unused entry
                    if (n_cur < 16) send_beat(OP_LOAD, 4'($urandom_range(n_cur, 15)),
                                              24'($urandom), $urandom);
                end else begin
                    send_beat(op, 4'($urandom), pick_flux(), $urandom);
                end
            end
            phase++;
        end

        wait_quiet();
        if (failures == 0)
            $display("bh_curve_interpolator: match");
        else
            $display("bh_curve_interpolator: mismatch");
        $finish;
    end

endmodule
